// ===== hdl/itoa_pkg.sv =====
// itoa_pkg: shared types, constants and the digit character function
// for the integer to ASCII formatter. No dependencies.
package itoa_pkg;

  localparam int unsigned ValueW    = 32;
  localparam int unsigned DigitW    = 4;
  localparam int unsigned CountW    = 4;
  localparam int unsigned MaxDigits = 10;
  localparam int unsigned QuotDecW  = 29;

  // Reciprocal of ten, scaled by 2^35; exact for every 32-bit dividend.
  localparam logic [ValueW-1:0] DecRecip  = 32'hCCCC_CCCD;
  localparam int unsigned       DecShift  = 35;

  localparam logic [7:0] AsciiMinus = 8'h2D;
  localparam logic [7:0] AsciiZero  = 8'h30;
  localparam logic [7:0] AsciiLowA  = 8'h61;

  typedef enum logic {
    OP_DEC = 1'b0,
    OP_HEX = 1'b1
  } opcode_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic [ValueW-1:0] quot;
    logic [DigitW-1:0] digit;
  } div_res_t;

  function automatic logic [7:0] digit_char(input logic [DigitW-1:0] d);
    logic [7:0] c;
    if (d < 4'd10) begin
      c = AsciiZero + 8'(d);
    end else begin
      c = AsciiLowA + 8'(d) - 8'd10;
    end
    return c;
  endfunction

endpackage

// ===== hdl/itoa_divstep.sv =====
// itoa_divstep: shared divide-by-base step, one digit per use.
// Decimal uses a reciprocal multiply, hex a 4-bit shift. Depends on itoa_pkg.
module itoa_divstep import itoa_pkg::*; (
  input  logic [ValueW-1:0] mag_i,
  input  logic              hex_i,
  output div_res_t          res_o
);

  logic [2*ValueW-1:0] prod;
  logic [QuotDecW-1:0] quot_dec;
  logic [DigitW-1:0]   q10_lo;
  logic [DigitW-1:0]   rem_dec;

  assign prod     = 64'(mag_i) * 64'(DecRecip);
  assign quot_dec = prod[2*ValueW-1:DecShift];
  // Only the low nibble of quot*10 is needed: the remainder is below ten.
  assign q10_lo   = 4'({quot_dec[2:0], 1'b0} + {quot_dec[0], 3'b000});
  assign rem_dec  = mag_i[DigitW-1:0] - q10_lo;

  always_comb begin
    if (hex_i) begin
      res_o.quot  = mag_i >> DigitW;
      res_o.digit = mag_i[DigitW-1:0];
    end else begin
      res_o.quot  = ValueW'(quot_dec);
      res_o.digit = rem_dec;
    end
  end

endmodule

// ===== hdl/integer_to_ascii_formatter_unit.sv =====
// integer_to_ascii_formatter_unit: top level, sequencer, digit buffer and
// output register. Depends on itoa_pkg and itoa_divstep.
//
// Converts one 32-bit word per transaction into ASCII, one character per
// output transaction, most significant first: signed decimal for opcode 0,
// lowercase hex for opcode 1. The shared divide step produces one digit
// per cycle least significant first into a ten-entry buffer, which is then
// read back one character per cycle while the output is not stalled. The
// input is not ready while a number is in progress; the last character may
// still wait in the output register while the next word is taken.
module integer_to_ascii_formatter_unit import itoa_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              opcode_i,
  input  logic [ValueW-1:0] value_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [7:0]        char_code_o,
  output logic              last_o,
  output logic [CountW-1:0] char_total_o
);

  state_e              state_q, state_d;
  logic [ValueW-1:0]   mag_q, mag_d;
  logic                hex_q, hex_d;
  logic                neg_q, neg_d;
  logic                sign_pend_q, sign_pend_d;
  logic [CountW-1:0]   ndig_q, ndig_d;
  logic [CountW-1:0]   idx_q, idx_d;
  logic [CountW-1:0]   cnt_q, cnt_d;
  logic [DigitW-1:0]   buf_q [MaxDigits];
  logic                out_valid_q, out_valid_d;
  logic [7:0]          char_q, char_d;
  logic                last_q, last_d;
  logic [CountW-1:0]   total_q, total_d;
  logic                buf_we;
  logic                in_acc;
  logic                slot_free;
  logic                is_neg;
  div_res_t            div_res;

  itoa_divstep u_divstep (
    .mag_i (mag_q),
    .hex_i (hex_q),
    .res_o (div_res)
  );

  assign in_ready_o   = (state_q == ST_IDLE);
  assign in_acc       = in_valid_i && in_ready_o;
  assign slot_free    = !out_valid_q || out_ready_i;
  assign is_neg       = (opcode_e'(opcode_i) == OP_DEC) && value_i[ValueW-1];
  assign out_valid_o  = out_valid_q;
  assign char_code_o  = char_q;
  assign last_o       = last_q;
  assign char_total_o = total_q;

  always_comb begin
    state_d     = state_q;
    mag_d       = mag_q;
    hex_d       = hex_q;
    neg_d       = neg_q;
    sign_pend_d = sign_pend_q;
    ndig_d      = ndig_q;
    idx_d       = idx_q;
    cnt_d       = cnt_q;
    buf_we      = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    char_d      = char_q;
    last_d      = last_q;
    total_d     = total_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          hex_d   = (opcode_e'(opcode_i) == OP_HEX);
          neg_d   = is_neg;
          mag_d   = is_neg ? (~value_i + 32'd1) : value_i;
          ndig_d  = '0;
          state_d = ST_CONV;
        end
      end
      ST_CONV: begin
        buf_we = 1'b1;
        mag_d  = div_res.quot;
        ndig_d = ndig_q + 4'd1;
        if (div_res.quot == '0) begin
          idx_d       = ndig_q;
          cnt_d       = '0;
          sign_pend_d = neg_q;
          state_d     = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          cnt_d       = cnt_q + 4'd1;
          if (sign_pend_q) begin
            char_d      = AsciiMinus;
            last_d      = 1'b0;
            total_d     = '0;
            sign_pend_d = 1'b0;
          end else begin
            char_d = digit_char(buf_q[idx_q]);
            idx_d  = idx_q - 4'd1;
            if (idx_q == '0) begin
              last_d  = 1'b1;
              total_d = cnt_q + 4'd1;
              state_d = ST_IDLE;
            end else begin
              last_d  = 1'b0;
              total_d = '0;
            end
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      sign_pend_q <= 1'b0;
      ndig_q      <= '0;
      idx_q       <= '0;
      cnt_q       <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      sign_pend_q <= sign_pend_d;
      ndig_q      <= ndig_d;
      idx_q       <= idx_d;
      cnt_q       <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q   <= mag_d;
    hex_q   <= hex_d;
    neg_q   <= neg_d;
    char_q  <= char_d;
    last_q  <= last_d;
    total_q <= total_d;
    if (buf_we) begin
      buf_q[ndig_q] <= div_res.digit;
    end
  end

  // Digit count never exceeds the buffer depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ndig_q <= 4'(MaxDigits))
    else $error("digit buffer overrun");

  // Hex numbers fit in eight digits.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CONV && hex_q) |-> ndig_q < 4'd8)
    else $error("hex conversion too long");

  // A pending sign only ever belongs to a decimal number.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    sign_pend_q |-> (!hex_q && neg_q))
    else $error("sign pending on non-negative number");

  // The character total is non-zero exactly on the last character.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (last_q ? (total_q != '0 && total_q <= 4'd11) : (total_q == '0)))
    else $error("character total inconsistent with last");

  // Output slot loaded only while emitting.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_q || out_ready_i) && state_q != ST_EMIT |=> !out_valid_q)
    else $error("character produced outside emit state");

endmodule
